// ===== sv/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// asgr_pkg
// Types, codes and SGR decoding functions for the ANSI SGR stream parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic [7:0]  attribute_bits;
        logic [2:0]  fore_kind;
        logic [23:0] fore_value;
        logic [2:0]  back_kind;
        logic [23:0] back_value;
        logic        segment_start;
    } out_t;

    typedef struct packed {
        logic [7:0]  attrs;
        logic [2:0]  fk;
        logic [23:0] fv;
        logic [2:0]  bk;
        logic [23:0] bv;
    } style_t;

    typedef enum logic [2:0] {
        CS_IDLE, CS_TYPE, CS_INDEX, CS_R, CS_G, CS_B
    } step_t;

    localparam logic [2:0] KIND_DEFAULT = 3'd0;
    localparam logic [2:0] KIND_STD     = 3'd1;
    localparam logic [2:0] KIND_BRIGHT  = 3'd2;
    localparam logic [2:0] KIND_INDEXED = 3'd3;
    localparam logic [2:0] KIND_RGB     = 3'd4;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CSI8  = 8'h9B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] FIN_LO   = 8'h40;
    localparam logic [7:0] FIN_HI   = 8'h7E;

    typedef struct packed {
        logic rst_style;
        logic begin_csi;
        logic emit;
        logic tok_feed;
        logic tok_apply;
        logic tok_clear;
        logic step_clear;
        logic commit;
        logic setup;
        logic rep_apply;
        logic [1:0] rep_idx;
    } cmd_t;

    typedef struct packed {
        logic       tok_started;
        logic       step_idle;
        logic       post_idle;
        logic [1:0] rep_len;
        logic       out_busy;
    } stat_t;

    typedef struct packed {
        style_t             ws;
        step_t              step;
        logic               back;
        logic signed [16:0] h0;
        logic signed [16:0] h1;
        logic signed [16:0] h2;
    } apply_res_t;

    function automatic logic [7:0] clamp8(logic signed [16:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [23:0] offset3(logic signed [16:0] c,
                                            logic signed [16:0] base);
        logic signed [16:0] d;
        d = c - base;
        return {21'd0, d[2:0]};
    endfunction

    function automatic style_t set_colour(style_t s, logic back, logic [2:0] kind,
                                          logic [23:0] value);
        style_t r;
        r = s;
        if (back) begin
            r.bk = kind;
            r.bv = value;
        end else begin
            r.fk = kind;
            r.fv = value;
        end
        return r;
    endfunction

    function automatic logic [2:0] attr_bit(logic [3:0] c);
        logic [2:0] r;
        case (c)
            4'd1: r = 3'd0;
            4'd2: r = 3'd1;
            4'd3: r = 3'd2;
            4'd4: r = 3'd3;
            4'd5: r = 3'd4;
            4'd6: r = 3'd4;
            4'd7: r = 3'd5;
            4'd8: r = 3'd6;
            4'd9: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic apply_res_t apply_code(style_t s, step_t st, logic back,
                                              logic signed [16:0] h0,
                                              logic signed [16:0] h1,
                                              logic signed [16:0] h2,
                                              logic signed [16:0] c);
        apply_res_t r;
        logic       ord;
        r.ws   = s;
        r.step = st;
        r.back = back;
        r.h0   = h0;
        r.h1   = h1;
        r.h2   = h2;
        ord    = 1'b0;
        case (st)
            CS_TYPE: begin
                r.h0 = c;
                if (c == 5) begin
                    r.step = CS_INDEX;
                end else if (c == 2) begin
                    r.step = CS_R;
                end else begin
                    r.ws   = set_colour(r.ws, back, KIND_DEFAULT, 24'd0);
                    r.step = CS_IDLE;
                    ord    = 1'b1;
                end
            end
            CS_INDEX: begin
                r.step = CS_IDLE;
                if (c >= 0 && c < 8) begin
                    r.ws = set_colour(r.ws, back, KIND_STD, {21'd0, c[2:0]});
                end else if (c >= 8 && c < 16) begin
                    r.ws = set_colour(r.ws, back, KIND_BRIGHT, {21'd0, c[2:0]});
                end else begin
                    r.ws = set_colour(r.ws, back, KIND_INDEXED, {16'd0, clamp8(c)});
                end
            end
            CS_R: begin
                r.h1   = c;
                r.step = CS_G;
            end
            CS_G: begin
                r.h2   = c;
                r.step = CS_B;
            end
            CS_B: begin
                r.step = CS_IDLE;
                r.ws   = set_colour(r.ws, back, KIND_RGB,
                                    {clamp8(h1), clamp8(h2), clamp8(c)});
            end
            default: begin
                ord = 1'b1;
            end
        endcase
        if (ord) begin
            if (c == 0) begin
                r.ws = '0;
            end else if (c >= 1 && c <= 9) begin
                r.ws.attrs[attr_bit(c[3:0])] = 1'b1;
            end else if (c == 22) begin
                r.ws.attrs[1:0] = 2'b00;
            end else if (c == 23) begin
                r.ws.attrs[2] = 1'b0;
            end else if (c == 24) begin
                r.ws.attrs[3] = 1'b0;
            end else if (c == 25) begin
                r.ws.attrs[4] = 1'b0;
            end else if (c == 27) begin
                r.ws.attrs[5] = 1'b0;
            end else if (c == 28) begin
                r.ws.attrs[6] = 1'b0;
            end else if (c == 29) begin
                r.ws.attrs[7] = 1'b0;
            end else if (c == 38) begin
                r.step = CS_TYPE;
                r.back = 1'b0;
            end else if (c == 48) begin
                r.step = CS_TYPE;
                r.back = 1'b1;
            end else if (c == 39) begin
                r.ws.fk = KIND_DEFAULT;
                r.ws.fv = 24'd0;
            end else if (c == 49) begin
                r.ws.bk = KIND_DEFAULT;
                r.ws.bv = 24'd0;
            end else if (c >= 30 && c <= 37) begin
                r.ws.fk = KIND_STD;
                r.ws.fv = offset3(c, 17'sd30);
            end else if (c >= 40 && c <= 47) begin
                r.ws.bk = KIND_STD;
                r.ws.bv = offset3(c, 17'sd40);
            end else if (c >= 90 && c <= 97) begin
                r.ws.fk = KIND_BRIGHT;
                r.ws.fv = offset3(c, 17'sd90);
            end else if (c >= 100 && c <= 107) begin
                r.ws.bk = KIND_BRIGHT;
                r.ws.bv = offset3(c, 17'sd100);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/asgr_dp.sv =====
// ----------------------------------------------------------------------------
// asgr_dp
// Datapath: styles, token decoder, colour sequence state, held codes and
// the output register.
// ----------------------------------------------------------------------------
module asgr_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  asgr_pkg::in_t   in_data,
    input  asgr_pkg::cmd_t  cmd,
    output asgr_pkg::stat_t stat,
    input  logic            m_ready,
    output logic            m_valid,
    output asgr_pkg::out_t  m_data
);

    asgr_pkg::style_t   cur_reg, cur_next;
    asgr_pkg::style_t   ws_reg, ws_next;
    asgr_pkg::step_t    step_reg, step_next;
    logic               back_reg, back_next;
    logic [15:0]        tok_reg, tok_next;
    logic               started_reg, started_next;
    logic               neg_reg, neg_next;
    logic               digit_reg, digit_next;
    logic               done_reg, done_next;
    logic               seg_reg, seg_next;
    logic signed [16:0] h0_reg, h0_next;
    logic signed [16:0] h1_reg, h1_next;
    logic signed [16:0] h2_reg, h2_next;
    logic signed [16:0] l0_reg, l0_next;
    logic signed [16:0] l1_reg, l1_next;
    logic signed [16:0] l2_reg, l2_next;
    logic               mv_reg, mv_next;
    asgr_pkg::out_t     md_reg, md_next;

    logic signed [16:0]   tok_code;
    logic signed [16:0]   rep_code;
    logic signed [16:0]   code;
    logic [19:0]          tok_mul;
    logic [7:0]           b;
    asgr_pkg::apply_res_t ap;

    assign b = in_data.byte_value;

    always_comb begin
        if (!digit_reg) begin
            tok_code = 17'sd0;
        end else if (neg_reg) begin
            tok_code = -$signed({1'b0, tok_reg});
        end else begin
            tok_code = $signed({1'b0, tok_reg});
        end
        case (cmd.rep_idx)
            2'd0: rep_code = l0_reg;
            2'd1: rep_code = l1_reg;
            default: rep_code = l2_reg;
        endcase
        code = cmd.rep_apply ? rep_code : tok_code;
        ap = asgr_pkg::apply_code(ws_reg, step_reg, back_reg, h0_reg, h1_reg, h2_reg,
                                  code);
        tok_mul = {4'd0, tok_reg} * 20'd10 + {12'd0, b - asgr_pkg::CH_ZERO};
    end

    always_comb begin
        cur_next     = cur_reg;
        ws_next      = ws_reg;
        step_next    = step_reg;
        back_next    = back_reg;
        tok_next     = tok_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        digit_next   = digit_reg;
        done_next    = done_reg;
        seg_next     = seg_reg;
        h0_next      = h0_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        l0_next      = l0_reg;
        l1_next      = l1_reg;
        l2_next      = l2_reg;
        mv_next      = mv_reg & ~m_ready;
        md_next      = md_reg;
        if (cmd.rst_style) begin
            cur_next     = '0;
            ws_next      = '0;
            step_next    = asgr_pkg::CS_IDLE;
            back_next    = 1'b0;
            tok_next     = 16'd0;
            started_next = 1'b0;
            neg_next     = 1'b0;
            digit_next   = 1'b0;
            done_next    = 1'b0;
            seg_next     = 1'b1;
        end else if (cmd.begin_csi) begin
            ws_next      = cur_reg;
            step_next    = asgr_pkg::CS_IDLE;
            back_next    = 1'b0;
            tok_next     = 16'd0;
            started_next = 1'b0;
            neg_next     = 1'b0;
            digit_next   = 1'b0;
            done_next    = 1'b0;
            seg_next     = 1'b1;
        end else begin
            if (cmd.tok_apply || cmd.rep_apply) begin
                ws_next   = ap.ws;
                step_next = ap.step;
                back_next = ap.back;
                h0_next   = ap.h0;
                h1_next   = ap.h1;
                h2_next   = ap.h2;
            end
            if (cmd.setup) begin
                l0_next   = h0_reg;
                l1_next   = h1_reg;
                l2_next   = h2_reg;
                ws_next   = asgr_pkg::set_colour(ws_reg, back_reg,
                                                 asgr_pkg::KIND_DEFAULT, 24'd0);
                step_next = asgr_pkg::CS_IDLE;
            end
            if (cmd.commit) begin
                cur_next = cmd.tok_apply ? ap.ws : ws_reg;
            end
            if (cmd.tok_feed) begin
                if (!done_reg) begin
                    if (b >= asgr_pkg::CH_ZERO && b <= asgr_pkg::CH_NINE) begin
                        tok_next   = (tok_mul > 20'd65535) ? 16'hFFFF : tok_mul[15:0];
                        digit_next = 1'b1;
                    end else if (b == asgr_pkg::CH_MINUS && !started_reg) begin
                        neg_next = 1'b1;
                    end else begin
                        done_next = 1'b1;
                    end
                end
                started_next = 1'b1;
            end
            if (cmd.tok_clear) begin
                tok_next     = 16'd0;
                started_next = 1'b0;
                neg_next     = 1'b0;
                digit_next   = 1'b0;
                done_next    = 1'b0;
            end
            if (cmd.step_clear) begin
                step_next = asgr_pkg::CS_IDLE;
            end
            if (cmd.emit) begin
                seg_next                = 1'b0;
                mv_next                 = 1'b1;
                md_next.text_byte       = b;
                md_next.attribute_bits  = cur_reg.attrs;
                md_next.fore_kind       = cur_reg.fk;
                md_next.fore_value      = cur_reg.fv;
                md_next.back_kind       = cur_reg.bk;
                md_next.back_value      = cur_reg.bv;
                md_next.segment_start   = seg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            ws_reg      <= '0;
            step_reg    <= asgr_pkg::CS_IDLE;
            back_reg    <= 1'b0;
            tok_reg     <= 16'd0;
            started_reg <= 1'b0;
            neg_reg     <= 1'b0;
            digit_reg   <= 1'b0;
            done_reg    <= 1'b0;
            seg_reg     <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            ws_reg      <= ws_next;
            step_reg    <= step_next;
            back_reg    <= back_next;
            tok_reg     <= tok_next;
            started_reg <= started_next;
            neg_reg     <= neg_next;
            digit_reg   <= digit_next;
            done_reg    <= done_next;
            seg_reg     <= seg_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        l0_reg <= l0_next;
        l1_reg <= l1_next;
        l2_reg <= l2_next;
        md_reg <= md_next;
    end

    always_comb begin
        stat.tok_started = started_reg;
        stat.step_idle   = (step_reg == asgr_pkg::CS_IDLE);
        stat.post_idle   = (ap.step == asgr_pkg::CS_IDLE);
        stat.out_busy    = mv_reg & ~m_ready;
        case (step_reg)
            asgr_pkg::CS_INDEX: stat.rep_len = 2'd1;
            asgr_pkg::CS_R:     stat.rep_len = 2'd1;
            asgr_pkg::CS_G:     stat.rep_len = 2'd2;
            asgr_pkg::CS_B:     stat.rep_len = 2'd3;
            default:            stat.rep_len = 2'd0;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule

// ===== sv/asgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// asgr_ctrl
// Controller: byte scanner state machine and colour replay sequencer.
// ----------------------------------------------------------------------------
module asgr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  asgr_pkg::in_t   in_data,
    input  asgr_pkg::stat_t stat,
    output asgr_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        GROUND, ESC, CSI_FIRST, CSI_MORE, OSC, OSC_ESC, SETUP, REPLAY
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] n_reg, n_next;
    logic       acc;
    logic       apply_m;
    logic [7:0] b;

    assign b       = in_data.byte_value;
    assign s_ready = (state_reg != SETUP) && (state_reg != REPLAY) && !stat.out_busy;
    assign acc     = s_valid && s_ready;
    assign apply_m = (state_reg == CSI_FIRST) || stat.tok_started;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        cmd        = '0;
        cmd.rep_idx = cnt_reg;
        case (state_reg)
            SETUP: begin
                if (stat.step_idle) begin
                    cmd.commit = 1'b1;
                    state_next = GROUND;
                end else begin
                    cmd.setup = 1'b1;
                    n_next    = stat.rep_len;
                    cnt_next  = 2'd0;
                    if (stat.rep_len != 2'd0) begin
                        state_next = REPLAY;
                    end
                end
            end
            REPLAY: begin
                cmd.rep_apply = 1'b1;
                if (cnt_reg == n_reg - 2'd1) begin
                    state_next = SETUP;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            default: begin
                if (acc) begin
                    if (in_data.operation) begin
                        cmd.rst_style = 1'b1;
                        state_next    = GROUND;
                    end else begin
                        case (state_reg)
                            GROUND: begin
                                if (b == asgr_pkg::CH_ESC) begin
                                    state_next = ESC;
                                end else if (b == asgr_pkg::CH_CSI8) begin
                                    cmd.begin_csi = 1'b1;
                                    state_next    = CSI_FIRST;
                                end else begin
                                    cmd.emit = 1'b1;
                                end
                            end
                            ESC: begin
                                if (b == asgr_pkg::CH_LBRK) begin
                                    cmd.begin_csi = 1'b1;
                                    state_next    = CSI_FIRST;
                                end else if (b == asgr_pkg::CH_RBRK) begin
                                    state_next = OSC;
                                end else begin
                                    state_next = GROUND;
                                end
                            end
                            CSI_FIRST, CSI_MORE: begin
                                if (b >= asgr_pkg::FIN_LO && b <= asgr_pkg::FIN_HI) begin
                                    cmd.tok_clear = 1'b1;
                                    state_next    = GROUND;
                                    if (b == asgr_pkg::CH_M) begin
                                        cmd.tok_apply = apply_m;
                                        if (apply_m ? stat.post_idle : stat.step_idle) begin
                                            cmd.commit = 1'b1;
                                        end else begin
                                            state_next = SETUP;
                                        end
                                    end else begin
                                        cmd.step_clear = 1'b1;
                                    end
                                end else if (b == asgr_pkg::CH_SEMI) begin
                                    cmd.tok_apply = 1'b1;
                                    cmd.tok_clear = 1'b1;
                                    state_next    = CSI_MORE;
                                end else begin
                                    cmd.tok_feed = 1'b1;
                                end
                            end
                            OSC: begin
                                if (b == asgr_pkg::CH_BEL) begin
                                    state_next = GROUND;
                                end else if (b == asgr_pkg::CH_ESC) begin
                                    state_next = OSC_ESC;
                                end
                            end
                            OSC_ESC: begin
                                if (b == asgr_pkg::CH_BSL || b == asgr_pkg::CH_BEL) begin
                                    state_next = GROUND;
                                end else if (b != asgr_pkg::CH_ESC) begin
                                    state_next = OSC;
                                end
                            end
                            default: begin
                                state_next = GROUND;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= GROUND;
            cnt_reg   <= 2'd0;
            n_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

endmodule

// ===== sv/ansi_sgr_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_stream_parser
// Parses a terminal byte stream and tags each text byte with its SGR style.
//
// The s_ channel takes one transaction per terminal byte, or a style reset
// when operation is set. The m_ channel delivers one transaction per text
// byte with the style in force when the byte arrived. Escape sequences,
// CSI sequences and OSC strings produce no output transaction.
// A byte is taken every cycle unless the output stalls or a replay runs; a
// text byte appears on the m_ channel in the cycle after it is accepted.
// When an 'm' final byte ends a CSI inside an unfinished 38/48 colour
// sequence, the replay sequencer runs and holds off the s_ channel.
// The output register holds a result while the receiver stalls; s_ready
// is high outside replay if the output register is free at the next edge.
// Reset returns the scanner to ground, default colours, no attributes and
// an empty output register.
// ----------------------------------------------------------------------------
module ansi_sgr_stream_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  asgr_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output asgr_pkg::out_t m_data
);

    asgr_pkg::cmd_t  cmd;
    asgr_pkg::stat_t stat;

    asgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_data (s_data),
        .stat    (stat),
        .cmd     (cmd)
    );

    asgr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the ANSI SGR stream parser.
//
// A clocked driver sends terminal bytes and style resets from a queue, with
// random gaps. A clocked monitor takes text byte transactions under random
// back pressure and compares every field with the styled bytes predicted by
// an independent scanner model kept inside this testbench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 20000;

    typedef enum logic [2:0] {
        SC_GROUND, SC_ESC, SC_CSI_FIRST, SC_CSI_MORE, SC_OSC, SC_OSC_ESC
    } scan_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    asgr_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    asgr_pkg::out_t m_data;

    asgr_pkg::in_t pending_bytes[$];
    asgr_pkg::out_t styled_bytes[$];
    int errors = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int take_gap = 0;
    bit hold_until_drained = 1'b0;
    bit stim_done = 1'b0;

    scan_t scan;
    asgr_pkg::style_t cur_style, work_style;
    int tok_mag;
    bit tok_started, tok_neg, tok_digit, tok_done;
    asgr_pkg::step_t cstep;
    bit cback;
    int held[4];
    bit seg_open;

    ansi_sgr_stream_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    function automatic int clip8(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic void paint(logic [2:0] kind, int value);
        if (cback) begin
            work_style.bk = kind;
            work_style.bv = 24'(value);
        end else begin
            work_style.fk = kind;
            work_style.fv = 24'(value);
        end
    endfunction

    function automatic void sgr_code(int c);
        bit plain;
        plain = 1'b1;
        case (cstep)
            asgr_pkg::CS_TYPE: begin
                held[0] = c;
                if (c == 5) begin
                    cstep = asgr_pkg::CS_INDEX;
                    plain = 1'b0;
                end else if (c == 2) begin
                    cstep = asgr_pkg::CS_R;
                    plain = 1'b0;
                end else begin
                    paint(asgr_pkg::KIND_DEFAULT, 0);
                    cstep = asgr_pkg::CS_IDLE;
                end
            end
            asgr_pkg::CS_INDEX: begin
                cstep = asgr_pkg::CS_IDLE;
                plain = 1'b0;
                if (c >= 0 && c < 8) paint(asgr_pkg::KIND_STD, c);
                else if (c >= 8 && c < 16) paint(asgr_pkg::KIND_BRIGHT, c - 8);
                else paint(asgr_pkg::KIND_INDEXED, clip8(c));
            end
            asgr_pkg::CS_R: begin
                held[1] = c;
                cstep = asgr_pkg::CS_G;
                plain = 1'b0;
            end
            asgr_pkg::CS_G: begin
                held[2] = c;
                cstep = asgr_pkg::CS_B;
                plain = 1'b0;
            end
            asgr_pkg::CS_B: begin
                cstep = asgr_pkg::CS_IDLE;
                plain = 1'b0;
                paint(asgr_pkg::KIND_RGB,
                      (clip8(held[1]) << 16) | (clip8(held[2]) << 8) | clip8(c));
            end
            default: ;
        endcase
        if (!plain) return;
        if (c == 0) work_style = '0;
        else if (c >= 1 && c <= 9) work_style.attrs[c == 1 ? 0 : (c <= 5 ? c - 1 : c - 2)] = 1'b1;
        else if (c == 22) work_style.attrs[1:0] = 2'b00;
        else if (c >= 23 && c <= 25) work_style.attrs[c - 21] = 1'b0;
        else if (c >= 27 && c <= 29) work_style.attrs[c - 22] = 1'b0;
        else if (c == 38 || c == 48) begin
            cstep = asgr_pkg::CS_TYPE;
            cback = (c == 48);
        end else if (c == 39) begin
            work_style.fk = asgr_pkg::KIND_DEFAULT;
            work_style.fv = 24'd0;
        end else if (c == 49) begin
            work_style.bk = asgr_pkg::KIND_DEFAULT;
            work_style.bv = 24'd0;
        end else if (c >= 30 && c <= 37) begin
            work_style.fk = asgr_pkg::KIND_STD;
            work_style.fv = 24'(c - 30);
        end else if (c >= 40 && c <= 47) begin
            work_style.bk = asgr_pkg::KIND_STD;
            work_style.bv = 24'(c - 40);
        end else if (c >= 90 && c <= 97) begin
            work_style.fk = asgr_pkg::KIND_BRIGHT;
            work_style.fv = 24'(c - 90);
        end else if (c >= 100 && c <= 107) begin
            work_style.bk = asgr_pkg::KIND_BRIGHT;
            work_style.bv = 24'(c - 100);
        end
    endfunction

    function automatic int token_now();
        if (!tok_digit) return 0;
        return tok_neg ? -tok_mag : tok_mag;
    endfunction

    function automatic void token_reset();
        tok_mag = 0;
        {tok_started, tok_neg, tok_digit, tok_done} = '0;
    endfunction

    function automatic void replay_colour();
        int saved[4];
        int n;
        while (cstep != asgr_pkg::CS_IDLE) begin
            n = (cstep == asgr_pkg::CS_B) ? 3 :
                (cstep == asgr_pkg::CS_G ? 2 : (cstep == asgr_pkg::CS_TYPE ? 0 : 1));
            saved = held;
            paint(asgr_pkg::KIND_DEFAULT, 0);
            cstep = asgr_pkg::CS_IDLE;
            for (int k = 0; k < n; k++) sgr_code(saved[k]);
        end
    endfunction

    function automatic void open_csi();
        work_style = cur_style;
        token_reset();
        cstep = asgr_pkg::CS_IDLE;
        cback = 1'b0;
        seg_open = 1'b1;
        scan = SC_CSI_FIRST;
    endfunction

    function automatic void model_reset();
        scan = SC_GROUND;
        cur_style = '0;
        work_style = '0;
        token_reset();
        cstep = asgr_pkg::CS_IDLE;
        cback = 1'b0;
        held = '{0, 0, 0, 0};
        seg_open = 1'b0;
    endfunction

    function automatic void predict(asgr_pkg::in_t t);
        logic [7:0] b;
        asgr_pkg::out_t o;
        b = t.byte_value;
        if (t.operation) begin
            cur_style = '0;
            work_style = '0;
            token_reset();
            cstep = asgr_pkg::CS_IDLE;
            cback = 1'b0;
            scan = SC_GROUND;
            seg_open = 1'b1;
            return;
        end
        case (scan)
            SC_ESC: begin
                if (b == asgr_pkg::CH_LBRK) open_csi();
                else if (b == asgr_pkg::CH_RBRK) scan = SC_OSC;
                else scan = SC_GROUND;
            end
            SC_CSI_FIRST, SC_CSI_MORE: begin
                if (b >= asgr_pkg::FIN_LO && b <= asgr_pkg::FIN_HI) begin
                    if (b == asgr_pkg::CH_M) begin
                        if (scan == SC_CSI_FIRST || tok_started) sgr_code(token_now());
                        replay_colour();
                        cur_style = work_style;
                    end
                    token_reset();
                    cstep = asgr_pkg::CS_IDLE;
                    scan = SC_GROUND;
                end else if (b == asgr_pkg::CH_SEMI) begin
                    sgr_code(token_now());
                    token_reset();
                    scan = SC_CSI_MORE;
                end else begin
                    if (!tok_done) begin
                        if (b >= asgr_pkg::CH_ZERO && b <= asgr_pkg::CH_NINE) begin
                            tok_mag = tok_mag * 10 + (int'(b) - int'(asgr_pkg::CH_ZERO));
                            if (tok_mag > 65535) tok_mag = 65535;
                            tok_digit = 1'b1;
                        end else if (b == asgr_pkg::CH_MINUS && !tok_started) tok_neg = 1'b1;
                        else tok_done = 1'b1;
                    end
                    tok_started = 1'b1;
                end
            end
            SC_OSC: begin
                if (b == asgr_pkg::CH_BEL) scan = SC_GROUND;
                else if (b == asgr_pkg::CH_ESC) scan = SC_OSC_ESC;
            end
            SC_OSC_ESC: begin
                if (b == asgr_pkg::CH_BSL || b == asgr_pkg::CH_BEL) scan = SC_GROUND;
                else if (b != asgr_pkg::CH_ESC) scan = SC_OSC;
            end
            default: begin
                scan = SC_GROUND;
                if (b == asgr_pkg::CH_ESC) scan = SC_ESC;
                else if (b == asgr_pkg::CH_CSI8) open_csi();
                else begin
                    o.text_byte = b;
                    o.attribute_bits = cur_style.attrs;
                    o.fore_kind = cur_style.fk;
                    o.fore_value = cur_style.fv;
                    o.back_kind = cur_style.bk;
                    o.back_value = cur_style.bv;
                    o.segment_start = seg_open;
                    seg_open = 1'b0;
                    styled_bytes = {styled_bytes, o};
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        asgr_pkg::in_t t;
        t.operation = 1'b0;
        t.byte_value = b;
        pending_bytes = {pending_bytes, t};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_reset();
        asgr_pkg::in_t t;
        t.operation = 1'b1;
        t.byte_value = 8'($urandom_range(0, 255));
        pending_bytes = {pending_bytes, t};
    endfunction

    function automatic string rand_code();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return $sformatf("%0d", $urandom_range(0, 9));
            1: return $sformatf("%0d", $urandom_range(21, 29));
            2: return $sformatf("%0d", $urandom_range(30, 49));
            3: return $sformatf("%0d", $urandom_range(90, 107));
            4, 5: return $sformatf("38;5;%0d", $urandom_range(0, 300));
            6, 7: return $sformatf("48;2;%0d;%0d;%0d", $urandom_range(0, 300),
                                   $urandom_range(0, 255), $urandom_range(0, 300));
            8: return $urandom_range(0, 1) ? "38" : "48";
            9: return $sformatf("%0d;%0d", $urandom_range(0, 1) ? 38 : 48, $urandom_range(0, 9));
            10: return "38;2;10";
            11: return "-5";
            12: return "99999";
            13: return "";
            14: return "3x7";
            15: return "48;5";
            default: return $sformatf("%0d", $urandom_range(0, 110));
        endcase
    endfunction

    function automatic void put_sgr();
        string s;
        int n;
        n = $urandom_range(0, 4);
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) s = {s, ";"};
            s = {s, rand_code()};
        end
        if ($urandom_range(0, 3) == 0) s = {s, ";"};
        if ($urandom_range(0, 1)) put_byte(asgr_pkg::CH_CSI8);
        else put_text("\033[");
        put_text(s);
        if ($urandom_range(0, 6) == 0)
            put_byte(8'($urandom_range(asgr_pkg::FIN_LO, asgr_pkg::FIN_HI)));
        else put_byte(asgr_pkg::CH_M);
    endfunction

    function automatic void put_noise();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0: put_text("\033]0;title\007");
            1: begin
                put_text("\033]2;a\033x");
                put_byte(8'($urandom_range(0, 255)));
                put_text("\033\\");
            end
            2: begin
                put_byte(asgr_pkg::CH_ESC);
                put_byte(8'($urandom_range(0, 255)));
            end
            3: put_reset();
            default: for (int i = 0; i < 4; i++) put_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || stim_done) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (hold_until_drained && styled_bytes.size() != 0) begin
            s_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
            s_data <= pending_bytes.pop_front();
            s_valid <= 1'b1;
            send_gap <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
        if (aresetn && s_valid && s_ready) predict(s_data);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (styled_bytes.size() == 0) begin
                    $display("%0t: unexpected output %h", $time, m_data);
                    errors++;
                end else if (styled_bytes[0] !== m_data) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             styled_bytes[0], m_data);
                    errors++;
                    void'(styled_bytes.pop_front());
                end else begin
                    void'(styled_bytes.pop_front());
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                take_gap <= ($urandom_range(0, 1)) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL ansi_sgr_stream_parser");
            $finish;
        end
    end

    initial begin
        model_reset();
        put_text("A");
        put_text("\033[1;2;3;4;5;6;7;8;9mB\033[22;23;24;25;27;28;29mC");
        put_text("\033[31;42;95;107mD\033[38;5;3;48;5;12mE");
        put_text("\033[38;5;999;48;2;-4;128;300mF\033[38;5mG");
        put_text("\033[48;2;1;2mH\033[38;7;1mI\033[mJ\033[-0;99999;mK");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("\033[31H\033]0;x\033y\007\033(Q");
        put_reset();
        put_text("Z");
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_bytes.size() == 0);
        for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 9) < 6) put_sgr();
            else put_noise();
            if (i == 50) begin
                wait (pending_bytes.size() == 0);
                hold_until_drained = 1'b1;
            end
            put_text("ab");
            if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)));
            wait (pending_bytes.size() < 8);
            if (i == 52) hold_until_drained = 1'b0;
        end
        wait (pending_bytes.size() == 0 && !s_valid);
        stim_done = 1'b1;
        wait (styled_bytes.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && styled_bytes.size() == 0) begin
            $display("PASS ansi_sgr_stream_parser");
        end else begin
            $display("FAIL ansi_sgr_stream_parser");
        end
        $finish;
    end
endmodule

// ===== ansi_sgr_stream_parser.f =====
sv/asgr_pkg.sv
sv/asgr_dp.sv
sv/asgr_ctrl.sv
sv/ansi_sgr_stream_parser.sv
tb/sv/tb_top.sv
